/* sv/beacon_tree_parent_selector_defines.svh */
// ----------------------------------------------------------------------------
// Beacon tree parent selector assertion macros
// Shared assertion wrappers, all clocked on clock.
// ----------------------------------------------------------------------------
`ifndef BEACON_TREE_PARENT_SELECTOR_DEFINES_SVH
`define BEACON_TREE_PARENT_SELECTOR_DEFINES_SVH

// Property that is not checked while reset is high.
`define BTPS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("beacon tree parent selector assertion failed");

// Property that is checked on every clock edge, reset included.
`define BTPS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("beacon tree parent selector assertion failed");

`endif

/* sv/btps_pkg.sv */
// ----------------------------------------------------------------------------
// Beacon tree parent selector package
// Request and result codes, register map, reset values and payload layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package btps_pkg;

   // Request kinds carried in the request tuser.
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_BEACON = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // Receive status codes.
   localparam logic [2:0] ST_ACCEPTED   = 3'd0;
   localparam logic [2:0] ST_BAD_LEN    = 3'd1;
   localparam logic [2:0] ST_WEAK       = 3'd2;
   localparam logic [2:0] ST_OLD        = 3'd3;
   localparam logic [2:0] ST_NOT_BETTER = 3'd4;
   localparam logic [2:0] ST_NO_BEACON  = 3'd5;

   // A well formed beacon carries this many payload bytes.
   localparam logic [6:0] VALID_BEACON_LEN = 7'd4;
   localparam logic [15:0] MAX_METRIC = 16'hFFFF;

   // Register map: register index is paddr[4:2].
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_NODE_IS_CONTROLLER = 3'd0;
   localparam logic [2:0] REG_RSSI_THRESHOLD     = 3'd1;
   localparam logic [2:0] REG_FIRST_FLOOD_DELAY  = 3'd2;
   localparam logic [2:0] REG_FORWARD_DELAY      = 3'd3;
   localparam logic [2:0] REG_FLOOD_INTERVAL     = 3'd4;

   // Register reset values.
   localparam logic        RST_NODE_IS_CONTROLLER = 1'b0;
   localparam logic [7:0]  RST_RSSI_THRESHOLD     = 8'hA1;   // -95
   localparam logic [15:0] RST_FIRST_FLOOD_DELAY  = 16'd128;
   localparam logic [15:0] RST_FORWARD_DELAY      = 16'd32;
   localparam logic [15:0] RST_FLOOD_INTERVAL     = 16'd7680;

   // Stream widths.
   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 1;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic              pad;
      logic [15:0]       sender_addr;
      logic [15:0]       rx_metric;
      logic [15:0]       rx_seqn;
      logic signed [7:0] rx_rssi;
      logic [6:0]        payload_length;
   } req_data_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [4:0]  pad;
      logic [15:0] tree_seqn;
      logic [15:0] hop_metric;
      logic [15:0] parent_addr;
      logic [2:0]  rx_status;
      logic [15:0] tx_metric;
      logic [15:0] tx_seqn;
   } rsp_data_type;

endpackage

`default_nettype wire

/* sv/beacon_tree_parent_selector.sv */
// ----------------------------------------------------------------------------
// Beacon tree parent selector
// Node side of hop-count beacon tree construction with a register port.
// ----------------------------------------------------------------------------
// Each request transaction (start, received beacon or timer tick) produces
// exactly one result transaction, via the input and then the result register.
// The block takes one transaction per clock cycle: a request is captured in
// an input register, then evaluated against the tree state in one pass of
// compares and an increment, and the tree state and the result register are
// written on the same edge, so the next request already sees the new state.
// A stalled result holds the input register; a new request is still taken in
// the cycle the waiting result leaves. Reads return immediately. The user
// writes APB-style port registers only with no request in flight; not enforced.
`default_nettype none

module beacon_tree_parent_selector (
   input  wire                              clock,
   input  wire                              reset,
   // Request stream.
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata: payload_length[6:0], rx_rssi[14:7], rx_seqn[30:15],
   //        rx_metric[46:31], sender_addr[62:47], zero pad[63]
   input  wire  [btps_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  wire  [btps_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result stream.
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: tx_seqn[15:0], tx_metric[31:16], rx_status[34:32],
   //        parent_addr[50:35], hop_metric[66:51], tree_seqn[82:67], zero pad[87:83]
   output logic [btps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: beacon_sent[0]
   output logic [btps_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // Configuration port.
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [btps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [btps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [btps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   import btps_pkg::*;

   // Configuration registers.
   logic        node_is_controller_ff;
   logic [7:0]  rssi_threshold_ff;
   logic [15:0] first_flood_delay_ff;
   logic [15:0] forward_delay_ff;
   logic [15:0] flood_interval_ff;

   // Tree state.
   logic [15:0] parent_link_ff, parent_link_in;
   logic [15:0] stored_metric_ff, stored_metric_in;
   logic [15:0] stored_seqn_ff, stored_seqn_in;
   logic [15:0] timer_count_ff, timer_count_in;
   logic        timer_armed_ff, timer_armed_in;

   // Input and result stages.
   logic         in_valid_ff;
   logic [1:0]   in_type_ff;
   req_data_type in_data_ff;
   logic         out_valid_ff;
   logic         out_sent_ff, out_sent_in;
   rsp_data_type out_data_ff, out_data_in;

   logic        advance;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [16:0] plus_one;
   logic [2:0]  status;
   logic [15:0] tx_seqn;
   logic [15:0] tx_metric;

   // Handshake: the input stage moves on when the result register is free.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sent_ff;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         node_is_controller_ff <= RST_NODE_IS_CONTROLLER;
         rssi_threshold_ff     <= RST_RSSI_THRESHOLD;
         first_flood_delay_ff  <= RST_FIRST_FLOOD_DELAY;
         forward_delay_ff      <= RST_FORWARD_DELAY;
         flood_interval_ff     <= RST_FLOOD_INTERVAL;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_NODE_IS_CONTROLLER: node_is_controller_ff <= csr_pwdata[0];
            REG_RSSI_THRESHOLD:     rssi_threshold_ff     <= csr_pwdata[7:0];
            REG_FIRST_FLOOD_DELAY:  first_flood_delay_ff  <= csr_pwdata[15:0];
            REG_FORWARD_DELAY:      forward_delay_ff      <= csr_pwdata[15:0];
            REG_FLOOD_INTERVAL:     flood_interval_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_NODE_IS_CONTROLLER: csr_prdata = {31'd0, node_is_controller_ff};
         REG_RSSI_THRESHOLD:     csr_prdata = {24'd0, rssi_threshold_ff};
         REG_FIRST_FLOOD_DELAY:  csr_prdata = {16'd0, first_flood_delay_ff};
         REG_FORWARD_DELAY:      csr_prdata = {16'd0, forward_delay_ff};
         REG_FLOOD_INTERVAL:     csr_prdata = {16'd0, flood_interval_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // Beacon metric plus one, kept at 17 bits for the comparison.
   assign plus_one = {1'b0, in_data_ff.rx_metric} + 17'd1;

   // Evaluate one request against the tree state.
   always_comb begin
      parent_link_in   = parent_link_ff;
      stored_metric_in = stored_metric_ff;
      stored_seqn_in   = stored_seqn_ff;
      timer_count_in   = timer_count_ff;
      timer_armed_in   = timer_armed_ff;
      status           = ST_NO_BEACON;
      out_sent_in      = 1'b0;
      tx_seqn          = '0;
      tx_metric        = '0;

      unique case (in_type_ff)
         REQ_START: begin
            if (node_is_controller_ff) begin
               stored_metric_in = '0;
               timer_count_in   = first_flood_delay_ff;
               timer_armed_in   = 1'b1;
            end
         end
         REQ_BEACON: begin
            priority if (in_data_ff.payload_length != VALID_BEACON_LEN) begin
               status = ST_BAD_LEN;
            end else if (in_data_ff.rx_rssi < $signed(rssi_threshold_ff)) begin
               status = ST_WEAK;
            end else if (in_data_ff.rx_seqn < stored_seqn_ff) begin
               status = ST_OLD;
            end else if (in_data_ff.rx_seqn == stored_seqn_ff &&
                         plus_one >= {1'b0, stored_metric_ff}) begin
               status = ST_NOT_BETTER;
            end else begin
               status           = ST_ACCEPTED;
               parent_link_in   = in_data_ff.sender_addr;
               stored_metric_in = plus_one[16] ? MAX_METRIC : plus_one[15:0];
               stored_seqn_in   = in_data_ff.rx_seqn;
               timer_count_in   = forward_delay_ff;
               timer_armed_in   = 1'b1;
            end
         end
         REQ_TICK: begin
            if (timer_armed_ff) begin
               if (timer_count_ff <= 16'd1) begin
                  // Timer expiry: transmit, and a controller schedules its next flood.
                  out_sent_in    = 1'b1;
                  tx_seqn        = stored_seqn_ff;
                  tx_metric      = stored_metric_ff;
                  timer_armed_in = 1'b0;
                  timer_count_in = '0;
                  if (node_is_controller_ff) begin
                     stored_seqn_in = stored_seqn_ff + 16'd1;
                     timer_count_in = flood_interval_ff;
                     timer_armed_in = 1'b1;
                  end
               end else begin
                  timer_count_in = timer_count_ff - 16'd1;
               end
            end
         end
         default: ;
      endcase

      out_data_in.pad         = '0;
      out_data_in.tx_seqn     = tx_seqn;
      out_data_in.tx_metric   = tx_metric;
      out_data_in.rx_status   = status;
      out_data_in.parent_addr = parent_link_in;
      out_data_in.hop_metric  = stored_metric_in;
      out_data_in.tree_seqn   = stored_seqn_in;
   end

   // Tree state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         parent_link_ff   <= '0;
         stored_metric_ff <= MAX_METRIC;
         stored_seqn_ff   <= '0;
         timer_count_ff   <= '0;
         timer_armed_ff   <= 1'b0;
      end else if (advance) begin
         parent_link_ff   <= parent_link_in;
         stored_metric_ff <= stored_metric_in;
         stored_seqn_ff   <= stored_seqn_in;
         timer_count_ff   <= timer_count_in;
         timer_armed_ff   <= timer_armed_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sent_ff <= out_sent_in;
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

/* sv/btps_checker.sv */
// ----------------------------------------------------------------------------
// Beacon tree parent selector checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "beacon_tree_parent_selector_defines.svh"

module btps_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [btps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire [btps_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import btps_pkg::*;

   rsp_data_type rsp;
   assign rsp = rsp_tdata;

   // No result transaction is offered right after reset.
   `BTPS_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_tvalid)

   // A stalled result keeps its payload.
   `BTPS_ASSERT(a_stall_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Transmit fields are zero unless a beacon goes out.
   `BTPS_ASSERT(a_tx_zero, rsp_tvalid && !rsp_tuser[0] |-> rsp.tx_seqn == 16'd0 && rsp.tx_metric == 16'd0)

   // A beacon goes out only on a tick, never on a received beacon.
   `BTPS_ASSERT(a_sent_on_tick, rsp_tvalid && rsp_tuser[0] |-> rsp.rx_status == ST_NO_BEACON)

   // An accepted beacon leaves a metric of at least one.
   `BTPS_ASSERT(a_accept_metric, rsp_tvalid && rsp.rx_status == ST_ACCEPTED |-> rsp.hop_metric != 16'd0)

endmodule

bind beacon_tree_parent_selector btps_checker u_btps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
